[design/psa_pkg.sv]
`timescale 1ns / 1ps
// shared constants for the pairwise sum accumulator
// no dependencies

package psa_pkg;

  // result field widths
  localparam int TOTAL_W = 48;
  localparam int ITEM_COUNT_W = 11;

  // parameter defaults
  localparam int MAX_ITEMS_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 16;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // pair term codes held in the mode register
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_ABS_DIFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIFF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd3;

endpackage

[design/pairwise_sum_accumulator.sv]
`timescale 1ns / 1ps
// Pairwise sum accumulator, top level.
// Input channel in_valid/in_stall carries in_start_req and a signed in_value.
// Each accepted request adds, over every earlier value of the current
// sequence, the pair term chosen by the mode register (absolute difference,
// later minus earlier, maximum, minimum) to a running total. One result per
// request on out_valid/out_stall: out_total, out_item_count, out_overflow.
// in_start_req clears count, sum and total before the value is taken.
// A request arriving with the store full is dropped and flagged by overflow.
// Requests wait in a two-entry queue, so the input can still take two of them
// while the engine walks or a result waits on a stalled receiver.
// In the walking modes the engine reads each stored value of the sequence in
// turn, one store read per cycle; difference mode instead uses one multiply
// against the running sum, and a dropped request goes straight to its result.
// Reset clears mode, count, totals and the queue; the value store is not
// cleared and needs no clearing pass. cfg_wr_en writes mode; the user must
// write it only while idle, the block does not enforce it. Results are held
// stable while out_stall is high. Depends on psa_pkg, psa_front and psa_back.

module pairwise_sum_accumulator #(
  parameter int MAX_ITEMS   = psa_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = psa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [psa_pkg::MODE_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_start_req,
  input  logic signed [VALUE_WIDTH-1:0]      in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [psa_pkg::TOTAL_W-1:0] out_total,
  output logic [psa_pkg::ITEM_COUNT_W-1:0]   out_item_count,
  output logic                               out_overflow
);

  logic                          q_valid;
  logic                          q_pop;
  logic                          q_start;
  logic signed [VALUE_WIDTH-1:0] q_value;

  psa_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_start_req (in_start_req),
    .in_value     (in_value),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_start      (q_start),
    .q_value      (q_value)
  );

  psa_back #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_start        (q_start),
    .q_value        (q_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_total      (out_total),
    .out_item_count (out_item_count),
    .out_overflow   (out_overflow)
  );

  // a dropped request only happens with the store full
  a_ovf_full : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_item_count == psa_pkg::ITEM_COUNT_W'(MAX_ITEMS))
    else $error("overflow flagged with store not full");

  // an accepted value always leaves at least one stored entry
  a_count_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> (MAX_ITEMS > 2047) || out_item_count != '0)
    else $error("stored value missing from count");

  // no result straight out of reset
  a_reset_quiet : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

[design/psa_front.sv]
`timescale 1ns / 1ps
// front end: takes input requests and holds them in a short queue
// uses psa_pkg for the queue depth

module psa_front #(
  parameter int VALUE_WIDTH = psa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_req,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic                          q_start,
  output logic signed [VALUE_WIDTH-1:0] q_value
);

  localparam int DEPTH = psa_pkg::QUEUE_DEPTH;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic                          start_r [DEPTH];
  logic signed [VALUE_WIDTH-1:0] value_r [DEPTH];
  logic [PW-1:0]                 wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]                 fill_r, fill_nxt;
  logic                          push, pop;

  assign in_stall = (fill_r == FW'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_start  = start_r[rd_ptr_r];
  assign q_value  = value_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      start_r[wr_ptr_r] <= in_start_req;
      value_r[wr_ptr_r] <= in_value;
    end
  end

endmodule

[design/psa_back.sv]
`timescale 1ns / 1ps
// back end: walks the value store, updates the running total, drives results
// uses psa_pkg for widths and mode codes

module psa_back #(
  parameter int MAX_ITEMS   = psa_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = psa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [psa_pkg::MODE_W-1:0]              cfg_wr_data,
  input  logic                                    q_valid,
  output logic                                    q_pop,
  input  logic                                    q_start,
  input  logic signed [VALUE_WIDTH-1:0]           q_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [psa_pkg::TOTAL_W-1:0]      out_total,
  output logic [psa_pkg::ITEM_COUNT_W-1:0]        out_item_count,
  output logic                                    out_overflow
);

  localparam int TW = psa_pkg::TOTAL_W;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int PW = VALUE_WIDTH + CW + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WALK   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIFF   = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic signed [VALUE_WIDTH-1:0] store_mem [MAX_ITEMS];

  logic [2:0]                    state_r, state_nxt;
  logic [psa_pkg::MODE_W-1:0]    mode_r, mode_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic signed [TW-1:0]          total_r, total_nxt;
  logic signed [TW-1:0]          sum_r, sum_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic                          rvalid_r, rvalid_nxt;
  logic signed [VALUE_WIDTH-1:0] rdata_r;
  logic signed [VALUE_WIDTH-1:0] a_r, a_nxt;
  logic signed [TW-1:0]          acc_r, acc_nxt;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [TW-1:0]          out_total_r, out_total_nxt;
  logic [psa_pkg::ITEM_COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                          out_ovf_r, out_ovf_nxt;
  logic                          store_wr;
  logic [CW-1:0]                 eff_count;
  logic signed [VALUE_WIDTH:0]   ax, ex, diff, term;

  assign out_valid      = out_valid_r;
  assign out_total      = out_total_r;
  assign out_item_count = out_count_r;
  assign out_overflow   = out_ovf_r;

  // pair term of the held value against the stored value just read
  always_comb begin
    ax   = (VALUE_WIDTH + 1)'(a_r);
    ex   = (VALUE_WIDTH + 1)'(rdata_r);
    diff = ax - ex;
    unique case (mode_r)
      psa_pkg::MODE_ABS_DIFF: term = diff[VALUE_WIDTH] ? -diff : diff;
      psa_pkg::MODE_MAX:      term = (ax >= ex) ? ax : ex;
      psa_pkg::MODE_MIN:      term = (ax <= ex) ? ax : ex;
      default:                term = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = cfg_wr_en ? cfg_wr_data : mode_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    rvalid_nxt    = 1'b0;
    a_nxt         = a_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_total_nxt = out_total_r;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    store_wr      = 1'b0;
    q_pop         = 1'b0;
    eff_count     = q_start ? '0 : count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          a_nxt = q_value;
          if (q_start) begin
            count_nxt = '0;
            total_nxt = '0;
            sum_nxt   = '0;
          end
          acc_nxt = '0;
          idx_nxt = '0;
          if (eff_count >= CW'(MAX_ITEMS)) begin
            ovf_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            ovf_nxt   = 1'b0;
            state_nxt = (mode_r == psa_pkg::MODE_DIFF) ? ST_MUL : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // one store read in flight; accumulate the entry read last cycle
        if (rvalid_r) begin
          acc_nxt = acc_r + TW'(term);
        end
        if (idx_r < count_r) begin
          idx_nxt    = idx_r + 1'b1;
          rvalid_nxt = 1'b1;
        end else if (!rvalid_r) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_MUL: begin
        prod_nxt  = PW'(a_r) * PW'($signed({1'b0, count_r}));
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        acc_nxt   = TW'(prod_r) - sum_r;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        total_nxt = total_r + acc_r;
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_r + TW'(a_r);
        store_wr  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          out_count_nxt = psa_pkg::ITEM_COUNT_W'(count_r);
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= psa_pkg::MODE_ABS_DIFF;
      count_r     <= '0;
      total_r     <= '0;
      sum_r       <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      sum_r       <= sum_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    a_r         <= a_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    ovf_r       <= ovf_nxt;
    out_total_r <= out_total_nxt;
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // value store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_mem[count_r[AW-1:0]] <= a_r;
    end
    rdata_r <= store_mem[idx_r[AW-1:0]];
  end

endmodule

[tb/sv/psa_sum_checker.sv]
`timescale 1ns / 1ps
// checker for the pairwise sum accumulator: watches the config port and both
// channels, predicts each result and compares it with what the block returns
// depends on psa_pkg

module psa_sum_checker #(
  parameter int MAX_ITEMS = psa_pkg::MAX_ITEMS_DEF,
  parameter int VALUE_W   = psa_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [psa_pkg::MODE_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_start_req,
  input  logic signed [VALUE_W-1:0]          in_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [psa_pkg::TOTAL_W-1:0] out_total,
  input  logic [psa_pkg::ITEM_COUNT_W-1:0]   out_item_count,
  input  logic                               out_overflow,
  output int                                 fail_count,
  output int                                 pending_count
);

  typedef struct packed {
    logic [psa_pkg::TOTAL_W-1:0]      total;
    logic [psa_pkg::ITEM_COUNT_W-1:0] item_count;
    logic                             overflow;
  } pair_sum_t;

  // shadow of the block state
  logic [psa_pkg::MODE_W-1:0]  mode_q;
  logic signed [VALUE_W-1:0]   seq_vals [MAX_ITEMS];
  int unsigned                 held;
  logic [psa_pkg::TOTAL_W-1:0] run_total;
  longint                      val_sum;

  pair_sum_t due_sums [$];
  pair_sum_t due;
  int        errs = 0;

  function automatic pair_sum_t predict_pair_sum(input logic start,
                                                 input logic signed [VALUE_W-1:0] raw);
    longint    a;
    longint    e;
    longint    inc;
    pair_sum_t r;
    a = longint'(raw);
    inc = 0;
    if (start) begin
      held = 0;
      run_total = '0;
      val_sum = 0;
    end
    r.overflow = 1'b0;
    if (held >= MAX_ITEMS) begin
      // store full: request dropped, totals untouched
      r.overflow = 1'b1;
    end else begin
      if (mode_q == psa_pkg::MODE_DIFF) begin
        inc = a * longint'(held) - val_sum;
      end else begin
        for (int i = 0; i < held; i++) begin
          e = longint'(seq_vals[i]);
          case (mode_q)
            psa_pkg::MODE_ABS_DIFF: inc += (a >= e) ? a - e : e - a;
            psa_pkg::MODE_MAX:      inc += (a >= e) ? a : e;
            psa_pkg::MODE_MIN:      inc += (a <= e) ? a : e;
            default:                inc += 0;
          endcase
        end
      end
      run_total = run_total + inc[psa_pkg::TOTAL_W-1:0];
      seq_vals[held] = raw;
      held++;
      val_sum += a;
    end
    r.total = run_total;
    r.item_count = held[psa_pkg::ITEM_COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q = psa_pkg::MODE_ABS_DIFF;
      held = 0;
      run_total = '0;
      val_sum = 0;
      due_sums.delete();
    end else begin
      // results first, so a request taken at this edge cannot cover a stray result
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (due_sums.size() == 0) begin
          errs++;
          $display("%0t unexpected result: total %0d item_count %0d overflow %0b",
                   $time, out_total, out_item_count, out_overflow);
        end else begin
          due = due_sums.pop_front();
          if (due.total !== out_total) begin
            errs++;
            $display("%0t total mismatch: expected %0d actual %0d",
                     $time, $signed(due.total), out_total);
          end
          if (due.item_count !== out_item_count) begin
            errs++;
            $display("%0t item_count mismatch: expected %0d actual %0d",
                     $time, due.item_count, out_item_count);
          end
          if (due.overflow !== out_overflow) begin
            errs++;
            $display("%0t overflow mismatch: expected %0b actual %0b",
                     $time, due.overflow, out_overflow);
          end
        end
      end
      if (cfg_wr_en === 1'b1) begin
        mode_q = cfg_wr_data;
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        due_sums.push_back(predict_pair_sum(in_start_req, in_value));
      end
    end
    fail_count <= errs;
    pending_count <= due_sums.size();
  end

endmodule

[tb/sv/tb_pairwise_sum_accumulator.sv]
`timescale 1ns / 1ps
// testbench top for the pairwise sum accumulator: clock, reset, requests,
// receiver stalls, watchdog and verdict; checking is left to psa_sum_checker
// depends on psa_pkg, psa_sum_checker and pairwise_sum_accumulator

module tb_pairwise_sum_accumulator;

  localparam int MAX_ITEMS      = psa_pkg::MAX_ITEMS_DEF;
  localparam int VALUE_W        = psa_pkg::VALUE_WIDTH_DEF;
  localparam int RAND_ITEMS     = 580;
  localparam int DRAIN_CYCLES   = MAX_ITEMS + 64;
  localparam int WATCHDOG_LIMIT = 20 * (MAX_ITEMS + 5);

  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_ZERO = '0;
  localparam logic signed [VALUE_W-1:0] VAL_ONE = VALUE_W'(1);
  localparam logic signed [VALUE_W-1:0] VAL_NEG_ONE = '1;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_wr_en = 1'b0;
  logic [psa_pkg::MODE_W-1:0]          cfg_wr_data = psa_pkg::MODE_ABS_DIFF;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                in_start_req = 1'b0;
  logic signed [VALUE_W-1:0]           in_value = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [psa_pkg::TOTAL_W-1:0]  out_total;
  logic [psa_pkg::ITEM_COUNT_W-1:0]    out_item_count;
  logic                                out_overflow;

  int fail_count;
  int pending_count;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  pairwise_sum_accumulator #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_WIDTH(VALUE_W)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_req  (in_start_req),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_total     (out_total),
    .out_item_count(out_item_count),
    .out_overflow  (out_overflow)
  );

  psa_sum_checker #(
    .MAX_ITEMS(MAX_ITEMS),
    .VALUE_W  (VALUE_W)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_req  (in_start_req),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_total     (out_total),
    .out_item_count(out_item_count),
    .out_overflow  (out_overflow),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
  end

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL pairwise_sum_accumulator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7, 0))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_ZERO;
      3:       return VAL_NEG_ONE;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic send_req(input logic start, input logic signed [VALUE_W-1:0] val);
    while ($urandom_range(99, 0) < idle_pct) begin
      // idle cycle with junk on the payload
      in_valid <= 1'b0;
      in_start_req <= 1'($urandom);
      in_value <= VALUE_W'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_req <= start;
    in_value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_mode(input logic [psa_pkg::MODE_W-1:0] m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_profile(input int p);
    case (p % 4)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 75; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 75; end
      default: begin idle_pct = 31; stall_pct <= 31; end
    endcase
  endtask

  initial begin
    int sent;
    int phase;
    int len;
    int start_pct;
    sent = 0;
    phase = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset mode is absolute difference; first request without a start
    send_req(1'b0, VAL_MAX);
    send_req(1'b0, VAL_MIN);
    send_req(1'b0, VAL_ZERO);
    send_req(1'b1, VAL_MIN);
    send_req(1'b0, VAL_MAX);
    send_req(1'b0, VAL_NEG_ONE);
    // switch mid-sequence, the running sum has to be valid already
    wait_drained();
    write_mode(psa_pkg::MODE_DIFF);
    send_req(1'b0, VAL_MAX);
    send_req(1'b0, VAL_MIN);
    send_req(1'b0, VAL_ONE);
    wait_drained();
    write_mode(psa_pkg::MODE_MAX);
    send_req(1'b1, VAL_MIN);
    send_req(1'b0, VAL_MAX);
    send_req(1'b0, VAL_MIN);
    send_req(1'b0, VAL_NEG_ONE);
    wait_drained();
    write_mode(psa_pkg::MODE_MIN);
    send_req(1'b0, VAL_MAX);
    send_req(1'b0, VAL_MIN);
    send_req(1'b1, VAL_ZERO);
    send_req(1'b1, VAL_MIN);
    send_req(1'b0, VAL_MAX);
    wait_drained();
    write_mode(psa_pkg::MODE_ABS_DIFF);
    send_req(1'b0, VAL_MIN);
    send_req(1'b0, VAL_MAX);

    // random phases; sequences often run on across a mode change
    while (sent < RAND_ITEMS) begin
      wait_drained();
      write_mode(psa_pkg::MODE_W'($urandom_range(3, 0)));
      set_profile(phase);
      case ($urandom_range(2, 0))
        0:       start_pct = 2;
        1:       start_pct = 10;
        default: start_pct = 40;
      endcase
      len = $urandom_range(40, 8);
      repeat (len) begin
        send_req($urandom_range(99, 0) < start_pct, pick_value());
        sent++;
      end
      phase++;
    end

    // fill the store in difference mode, then push past capacity
    wait_drained();
    write_mode(psa_pkg::MODE_DIFF);
    set_profile(phase);
    send_req(1'b1, pick_value());
    repeat (MAX_ITEMS - 1) send_req(1'b0, pick_value());
    repeat (4) send_req(1'b0, pick_value());
    // full store seen from a walking mode
    wait_drained();
    write_mode(psa_pkg::MODE_ABS_DIFF);
    set_profile(phase + 1);
    repeat (3) send_req(1'b0, pick_value());
    // a start while full clears the store
    wait_drained();
    write_mode(psa_pkg::MODE_MIN);
    send_req(1'b1, pick_value());
    repeat (3) send_req(1'b0, pick_value());

    wait_drained();
    stall_pct <= 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS pairwise_sum_accumulator");
    end else begin
      $display("FAIL pairwise_sum_accumulator");
    end
    $finish;
  end

endmodule

[files.f]
design/psa_pkg.sv
design/psa_front.sv
design/psa_back.sv
design/pairwise_sum_accumulator.sv
tb/sv/psa_sum_checker.sv
tb/sv/tb_pairwise_sum_accumulator.sv
